// ===== hdl/lge_pkg.sv =====
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types and constants for the life generation engine.
// ----------------------------------------------------------------------------
package lge_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_RUN  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_ROWS = 2'd0,
        REG_COLS = 2'd1,
        REG_WRAP = 2'd2,
        REG_GENS = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEEK,
        S_PREV,
        S_ZERO,
        S_GEN,
        S_FIN
    } t_state;

    localparam int SIZE_W       = 7;
    localparam int GEN_W        = 16;
    localparam int POS_W        = 6;
    localparam int CFG_W        = 16;
    localparam int SIZE_RESET   = 64;
    localparam int GENS_RESET   = 100;

endpackage

// ===== hdl/lge_row_cell.sv =====
// ----------------------------------------------------------------------------
// lge_row_cell
// One stage of the row ring: holds one grid row and takes its neighbor's row
// whenever the ring shifts.
// ----------------------------------------------------------------------------
module lge_row_cell #(
    parameter int MAX_COLS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [MAX_COLS-1:0] i_d,
    output logic [MAX_COLS-1:0] o_q
);

    logic [MAX_COLS-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_shift) begin
            r_row <= i_d;
        end
    end

    assign o_q = r_row;

endmodule

// ===== hdl/lge_rule.sv =====
// ----------------------------------------------------------------------------
// lge_rule
// Computes the next value of one whole row under rule B3/S23 from the rows
// above, at and below it. Columns past the grid in use keep their value.
// ----------------------------------------------------------------------------
module lge_rule #(
    parameter int MAX_COLS = 64
) (
    input  logic [MAX_COLS-1:0]         i_prv,
    input  logic [MAX_COLS-1:0]         i_cur,
    input  logic [MAX_COLS-1:0]         i_nxt,
    input  logic [$clog2(MAX_COLS)-1:0] i_nc_m1,
    input  logic                        i_wrap,
    output logic [MAX_COLS-1:0]         o_new
);

    localparam int CIW = $clog2(MAX_COLS);

    logic [2:0] w_lft;
    logic [2:0] w_rgt;

    // Bits that the first and last column in use see past the edge.
    assign w_lft = i_wrap ? {i_nxt[i_nc_m1], i_cur[i_nc_m1], i_prv[i_nc_m1]} : 3'b000;
    assign w_rgt = i_wrap ? {i_nxt[0], i_cur[0], i_prv[0]} : 3'b000;

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
        logic [2:0] l;
        logic [2:0] r;
        logic [3:0] n;
        logic       in_use;
        logic       last;

        assign last   = (CIW'(c) == i_nc_m1);
        assign in_use = (CIW'(c) <= i_nc_m1);

        if (c == 0) begin : g_l0
            assign l = w_lft;
        end else begin : g_ln
            assign l = {i_nxt[c-1], i_cur[c-1], i_prv[c-1]};
        end

        if (c == MAX_COLS - 1) begin : g_rl
            assign r = w_rgt;
        end else begin : g_rn
            assign r = last ? w_rgt : {i_nxt[c+1], i_cur[c+1], i_prv[c+1]};
        end

        assign n = 4'(l[0]) + 4'(l[1]) + 4'(l[2]) + 4'(r[0]) + 4'(r[1]) + 4'(r[2])
                 + 4'(i_prv[c]) + 4'(i_nxt[c]);

        assign o_new[c] = in_use ? ((n == 4'd3) || ((n == 4'd2) && i_cur[c])) : i_cur[c];
    end

endmodule

// ===== hdl/life_generation_engine.sv =====
// ----------------------------------------------------------------------------
// life_generation_engine
// Conway's Game of Life (B3/S23) on a grid of up to MAX_ROWS by MAX_COLS.
// ----------------------------------------------------------------------------
// The grid lives in a ring of MAX_ROWS row cells that rotates one row per
// cycle while it shifts, and holds while idle or while a result waits; in a
// lap a rule unit updates the whole row at the ring head each cycle. Each
// generation of a run item first rotates the ring to pick up the wrapped
// upper row and to bring row 0 back to the head, then makes one full lap of
// the ring. Load and read items rotate the ring to the addressed row. Every
// item gives one result item; the next item is taken once the result has
// been handed to the output register.
// ----------------------------------------------------------------------------
module life_generation_engine #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // tdata: command[1:0], row[7:2], col[13:8], alive_in[14], zero[15]
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [15:0]               s_axis_tdata,
    // tdata: alive_out[0], done_res[1], zero[7:2]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [lge_pkg::CFG_W-1:0] i_cfg_data
);

    import lge_pkg::*;

    localparam int RIW = $clog2(MAX_ROWS);
    localparam int CIW = $clog2(MAX_COLS);

    logic [SIZE_W-1:0] r_grid_rows;
    logic [SIZE_W-1:0] r_grid_cols;
    logic              r_wrap;
    logic [GEN_W-1:0]  r_gens_cfg;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [POS_W-1:0]  r_row, n_row;
    logic [POS_W-1:0]  r_col, n_col;
    logic              r_alive, n_alive;
    logic [RIW-1:0]    r_head, n_head;
    logic [RIW-1:0]    r_step, n_step;
    logic [GEN_W-1:0]  r_gen, n_gen;
    logic              r_res_alive, n_res_alive;
    logic              r_res_done, n_res_done;
    logic [MAX_COLS-1:0] r_prev, n_prev;
    logic [MAX_COLS-1:0] r_first, n_first;
    logic              r_out_valid;
    logic [7:0]        r_out_data;

    logic                w_shift;
    logic [MAX_COLS-1:0] w_tail;
    logic [MAX_COLS-1:0] w_row [MAX_ROWS];
    logic [MAX_COLS-1:0] w_mod;
    logic [MAX_COLS-1:0] w_nxt;
    logic [MAX_COLS-1:0] w_new;
    logic [RIW-1:0]      w_nr_m1;
    logic [CIW-1:0]      w_nc_m1;
    logic [RIW-1:0]      w_head_inc;
    logic                w_inside;
    logic                w_out_load;
    logic [CIW-1:0]      w_col_i;

    // Sizes in use: zero acts as one, anything above the maximum as the maximum.
    always_comb begin
        if (r_grid_rows == '0) begin
            w_nr_m1 = '0;
        end else if (32'(r_grid_rows) > 32'(MAX_ROWS)) begin
            w_nr_m1 = RIW'(MAX_ROWS - 1);
        end else begin
            w_nr_m1 = RIW'(32'(r_grid_rows) - 32'd1);
        end
        if (r_grid_cols == '0) begin
            w_nc_m1 = '0;
        end else if (32'(r_grid_cols) > 32'(MAX_COLS)) begin
            w_nc_m1 = CIW'(MAX_COLS - 1);
        end else begin
            w_nc_m1 = CIW'(32'(r_grid_cols) - 32'd1);
        end
    end

    assign w_head_inc = (32'(r_head) == 32'(MAX_ROWS - 1)) ? '0 : r_head + RIW'(1);
    assign w_inside   = (32'(r_row) <= 32'(w_nr_m1)) && (32'(r_col) <= 32'(w_nc_m1));
    assign w_col_i    = CIW'(r_col);

    always_comb begin
        w_mod          = w_row[0];
        w_mod[w_col_i] = r_alive;
    end

    // Row below the head; the last row in use sees old row 0 with wrap, else zeros.
    always_comb begin
        if (r_step == w_nr_m1) begin
            if (!r_wrap) begin
                w_nxt = '0;
            end else if (r_step == '0) begin
                w_nxt = w_row[0];
            end else begin
                w_nxt = r_first;
            end
        end else begin
            w_nxt = w_row[1];
        end
    end

    lge_rule #(.MAX_COLS(MAX_COLS)) u_rule (
        .i_prv   (r_prev),
        .i_cur   (w_row[0]),
        .i_nxt   (w_nxt),
        .i_nc_m1 (w_nc_m1),
        .i_wrap  (r_wrap),
        .o_new   (w_new)
    );

    for (genvar k = 0; k < MAX_ROWS; k++) begin : g_ring
        logic [MAX_COLS-1:0] d;
        if (k == MAX_ROWS - 1) begin : g_tail
            assign d = w_tail;
        end else begin : g_link
            assign d = w_row[k+1];
        end
        lge_row_cell #(.MAX_COLS(MAX_COLS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     (d),
            .o_q     (w_row[k])
        );
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_out_load    = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_row       = r_row;
        n_col       = r_col;
        n_alive     = r_alive;
        n_head      = r_head;
        n_step      = r_step;
        n_gen       = r_gen;
        n_res_alive = r_res_alive;
        n_res_done  = r_res_done;
        n_prev      = r_prev;
        n_first     = r_first;
        w_shift     = 1'b0;
        w_tail      = w_row[0];
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd       = t_cmd'(s_axis_tdata[1:0]);
                    n_row       = s_axis_tdata[7:2];
                    n_col       = s_axis_tdata[13:8];
                    n_alive     = s_axis_tdata[14];
                    n_res_alive = 1'b0;
                    n_res_done  = 1'b0;
                    case (t_cmd'(s_axis_tdata[1:0]))
                        CMD_LOAD, CMD_READ: n_state = S_SEEK;
                        CMD_RUN: begin
                            n_gen = r_gens_cfg;
                            if (r_gens_cfg == '0) begin
                                n_res_done = 1'b1;
                                n_state    = S_FIN;
                            end else begin
                                n_state = S_PREV;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SEEK: begin
                if (!w_inside) begin
                    n_state = S_FIN;
                end else if (32'(r_head) == 32'(r_row)) begin
                    if (r_cmd == CMD_LOAD) begin
                        w_shift = 1'b1;
                        w_tail  = w_mod;
                        n_head  = w_head_inc;
                    end else begin
                        n_res_alive = w_row[0][w_col_i];
                    end
                    n_state = S_FIN;
                end else begin
                    w_shift = 1'b1;
                    n_head  = w_head_inc;
                end
            end
            S_PREV: begin
                if (r_head == w_nr_m1) begin
                    n_prev  = r_wrap ? w_row[0] : '0;
                    n_state = S_ZERO;
                end else begin
                    w_shift = 1'b1;
                    n_head  = w_head_inc;
                end
            end
            S_ZERO: begin
                if (r_head == '0) begin
                    n_step  = '0;
                    n_state = S_GEN;
                end else begin
                    w_shift = 1'b1;
                    n_head  = w_head_inc;
                end
            end
            S_GEN: begin
                w_shift = 1'b1;
                w_tail  = (r_step <= w_nr_m1) ? w_new : w_row[0];
                n_head  = w_head_inc;
                n_prev  = w_row[0];
                if (r_step == '0) begin
                    n_first = w_row[0];
                end
                if (32'(r_step) == 32'(MAX_ROWS - 1)) begin
                    n_step = '0;
                    n_gen  = r_gen - GEN_W'(1);
                    if (r_gen == GEN_W'(1)) begin
                        n_res_done = 1'b1;
                        n_state    = S_FIN;
                    end else begin
                        n_state = S_PREV;
                    end
                end else begin
                    n_step = r_step + RIW'(1);
                end
            end
            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_out_valid <= 1'b0;
            r_grid_rows <= SIZE_W'(SIZE_RESET);
            r_grid_cols <= SIZE_W'(SIZE_RESET);
            r_wrap      <= 1'b0;
            r_gens_cfg  <= GEN_W'(GENS_RESET);
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_ROWS: r_grid_rows <= i_cfg_data[SIZE_W-1:0];
                    REG_COLS: r_grid_cols <= i_cfg_data[SIZE_W-1:0];
                    REG_WRAP: r_wrap      <= i_cfg_data[0];
                    REG_GENS: r_gens_cfg  <= i_cfg_data[GEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_row       <= n_row;
        r_col       <= n_col;
        r_alive     <= n_alive;
        r_step      <= n_step;
        r_gen       <= n_gen;
        r_res_alive <= n_res_alive;
        r_res_done  <= n_res_done;
        r_prev      <= n_prev;
        r_first     <= n_first;
        if (w_out_load) begin
            r_out_data <= {6'b0, r_res_done, r_res_alive};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A lap always starts with row 0 at the head of the ring.
    a_lap_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEN && r_step == '0) |-> (r_head == '0))
        else $error("generation lap started off row 0");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_head) < 32'(MAX_ROWS))
        else $error("ring head out of range");

    a_last_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEN && 32'(r_step) == 32'(MAX_ROWS - 1) && r_gen == GEN_W'(1))
        |=> (r_state == S_FIN && r_res_done))
        else $error("run did not finish after its last generation");

    a_take_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_cmd) || $past(r_state) == S_IDLE)
        else $error("command changed during an item");

endmodule
